@@ sv/mcmp_pkg.sv @@
package mcmp_pkg;

  typedef enum logic [1:0] {
    KIND_NOTE_OFF = 2'd0,
    KIND_NOTE_ON  = 2'd1,
    KIND_CTRL     = 2'd2,
    KIND_PROGRAM  = 2'd3
  } msg_kind_e;

  // Bytes of an open message taken so far, the status byte included.
  localparam logic [1:0] HELD_NONE   = 2'd0;
  localparam logic [1:0] HELD_STATUS = 2'd1;
  localparam logic [1:0] HELD_FIRST  = 2'd2;

  localparam int unsigned StatusFlagBit = 7;

  typedef struct packed {
    msg_kind_e   msg_kind;
    logic [3:0]  chan;
    logic [7:0]  data_one;
    logic [7:0]  data_two;
  } msg_t;

  // True for the status nibbles that open a supported channel message.
  function automatic logic status_known(input logic [7:0] status);
    logic known;
    case (status[7:4])
      4'h8, 4'h9, 4'hB, 4'hC: known = 1'b1;
      default:                known = 1'b0;
    endcase
    return known;
  endfunction

  function automatic msg_kind_e status_kind(input logic [7:0] status);
    msg_kind_e kind;
    case (status[7:4])
      4'h8:    kind = KIND_NOTE_OFF;
      4'h9:    kind = KIND_NOTE_ON;
      4'hB:    kind = KIND_CTRL;
      default: kind = KIND_PROGRAM;
    endcase
    return kind;
  endfunction

endpackage

@@ sv/mcmp_byte_if.sv @@
interface mcmp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] midi_byte;

  modport source (output valid, output midi_byte, input ready);
  modport sink   (input valid, input midi_byte, output ready);
endinterface

@@ sv/mcmp_msg_if.sv @@
interface mcmp_msg_if;
  logic       valid;
  logic       ready;
  logic [1:0] msg_kind;
  logic [3:0] chan;
  logic [7:0] data_one;
  logic [7:0] data_two;

  modport source (output valid, output msg_kind, output chan, output data_one,
                  output data_two, input ready);
  modport sink   (input valid, input msg_kind, input chan, input data_one,
                  input data_two, output ready);
endinterface

@@ sv/mcmp_in_reg.sv @@
module mcmp_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  logic [7:0] midi_byte_i,
  output logic       ready_o,
  output logic       valid_o,
  output logic [7:0] midi_byte_o,
  input  logic       ready_i
);
  logic       valid_q;
  logic       valid_d;
  logic [7:0] byte_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      byte_q <= midi_byte_i;
    end
  end

  assign valid_o     = valid_q;
  assign midi_byte_o = byte_q;
endmodule

@@ sv/mcmp_parser.sv @@
module mcmp_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [7:0]    midi_byte_i,
  output logic          ready_o,
  output logic          res_valid_o,
  output mcmp_pkg::msg_t res_o,
  input  logic          res_ready_i
);
  import mcmp_pkg::*;

  logic       in_msg_q, in_msg_d;
  logic [1:0] held_q, held_d;
  logic [7:0] status_q, status_d;
  logic [7:0] first_q, first_d;
  logic       consume;
  logic       emit;
  msg_kind_e  kind;
  logic       is_program;

  assign ready_o    = res_ready_i;
  assign consume    = valid_i && res_ready_i;
  assign kind       = status_kind(status_q);
  assign is_program = (kind == KIND_PROGRAM);

  always_comb begin
    in_msg_d = in_msg_q;
    held_d   = held_q;
    status_d = status_q;
    first_d  = first_q;
    emit     = 1'b0;
    if (consume) begin
      if (!in_msg_q) begin
        if (midi_byte_i[StatusFlagBit]) begin
          status_d = midi_byte_i;
          in_msg_d = status_known(midi_byte_i);
          held_d   = status_known(midi_byte_i) ? HELD_STATUS : HELD_NONE;
        end
      end else if (!status_known(status_q)) begin
        in_msg_d = 1'b0;
        held_d   = HELD_NONE;
      end else if (held_q == HELD_STATUS && !is_program) begin
        first_d = midi_byte_i;
        held_d  = HELD_FIRST;
      end else begin
        // Any other count completes the message with this byte.
        emit     = 1'b1;
        in_msg_d = 1'b0;
        held_d   = HELD_NONE;
      end
    end
  end

  always_comb begin
    res_o.msg_kind = kind;
    res_o.chan     = status_q[3:0];
    res_o.data_one = is_program ? midi_byte_i : first_q;
    res_o.data_two = is_program ? 8'd0 : midi_byte_i;
  end

  assign res_valid_o = emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_msg_q <= 1'b0;
      held_q   <= HELD_NONE;
      status_q <= 8'd0;
      first_q  <= 8'd0;
    end else begin
      in_msg_q <= in_msg_d;
      held_q   <= held_d;
      status_q <= status_d;
      first_q  <= first_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_open_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_msg_q |-> (held_q == HELD_STATUS || held_q == HELD_FIRST))
    else $error("open message with bad byte count");
  a_idle_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_msg_q |-> held_q == HELD_NONE)
    else $error("idle parser holds bytes");
  a_emit_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> !in_msg_q && $stable(status_q))
    else $error("message not closed after result");
  a_emit_needs_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> in_msg_q && consume)
    else $error("result without an open message");
`endif
endmodule

@@ sv/mcmp_out_reg.sv @@
module mcmp_out_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  mcmp_pkg::msg_t msg_i,
  output logic           ready_o,
  output logic           valid_o,
  output mcmp_pkg::msg_t msg_o,
  input  logic           ready_i
);
  import mcmp_pkg::*;

  logic valid_q;
  logic valid_d;
  msg_t msg_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      msg_q <= msg_i;
    end
  end

  assign valid_o = valid_q;
  assign msg_o   = msg_q;
endmodule

@@ sv/midi_channel_message_parser.sv @@
// Parser for MIDI channel voice messages. One received byte enters per
// transaction on byte_i, and each finished note off, note on, control change
// or program change message leaves as one transaction on msg_o, carrying the
// kind, the channel from the low nibble of the status byte and the data bytes
// (data_two is zero for program change). While idle, a byte with bit 7 set
// opens a message and a byte with bit 7 clear is ignored; once a message is
// open, every byte is taken as data, even one with bit 7 set. A status byte of
// any other kind is dropped at once. There is no running status and no system
// or realtime message handling. The block takes one byte every clock cycle
// while msg_o keeps up. A byte accepted into the input register waits there
// until the parser works on it, and a result that the parser completes is
// loaded into the output register, which drives msg_o. The parser advances
// only when the output register can take a result. While msg_o is stalled
// with a result waiting, the parser holds, one more byte can still enter the
// input register, and byte_i then stalls until msg_o accepts the waiting
// result.
module midi_channel_message_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  mcmp_byte_if.sink          byte_i,
  mcmp_msg_if.source         msg_o
);
  import mcmp_pkg::*;

  // Input register to parser.
  logic       in_valid;
  logic [7:0] in_byte;
  logic       parse_ready;

  // Parser to result register.
  logic       res_valid;
  msg_t       res_msg;
  logic       res_ready;

  msg_t       out_msg;

  mcmp_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (byte_i.valid),
    .midi_byte_i (byte_i.midi_byte),
    .ready_o     (byte_i.ready),
    .valid_o     (in_valid),
    .midi_byte_o (in_byte),
    .ready_i     (parse_ready)
  );

  // The parser consumes a byte only when the result register can take a
  // result, so the state never moves ahead of a result that has no room.
  mcmp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (in_valid),
    .midi_byte_i (in_byte),
    .ready_o     (parse_ready),
    .res_valid_o (res_valid),
    .res_o       (res_msg),
    .res_ready_i (res_ready)
  );

  mcmp_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (res_valid),
    .msg_i   (res_msg),
    .ready_o (res_ready),
    .valid_o (msg_o.valid),
    .msg_o   (out_msg),
    .ready_i (msg_o.ready)
  );

  assign msg_o.msg_kind = out_msg.msg_kind;
  assign msg_o.chan     = out_msg.chan;
  assign msg_o.data_one = out_msg.data_one;
  assign msg_o.data_two = out_msg.data_two;
endmodule
